// ===== sv/ale_pkg.sv =====
// ale_pkg: request kinds and result status codes of the array list engine
// no dependencies; used by the top level and its checker
`default_nettype none

package ale_pkg;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_SEARCH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

`default_nettype wire

// ===== sv/ale_if.sv =====
// ale_req_if and ale_rsp_if: valid/ready channels of the array list engine
// no dependencies; widths set by the instantiating level
`default_nettype none

interface ale_req_if #(
  parameter int PW = 7,
  parameter int VW = 32
);
  logic          valid;
  logic          ready;
  logic [1:0]    kind;
  logic [PW-1:0] position;
  logic [VW-1:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink (input valid, kind, position, value, output ready);
endinterface

interface ale_rsp_if #(
  parameter int PW = 7
);
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic          found;
  logic [PW-1:0] where;
  logic [PW-1:0] count;

  modport source (output valid, status, found, where, count, input ready);
  modport sink (input valid, status, found, where, count, output ready);
endinterface

`default_nettype wire

// ===== sv/ale_mem.sv =====
// ale_mem: list storage, one write port and one read port with registered data
// no dependencies
`default_nettype none

module ale_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AddrW-1:0]         waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [AddrW-1:0]         raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

`default_nettype wire

// ===== sv/array_list_engine_unit.sv =====
// array_list_engine_unit: ordered list of words with append, insert, delete and search
// depends on ale_pkg, ale_if (ale_req_if, ale_rsp_if) and ale_mem
//
// The list lives in a single-port-write, single-port-read memory of DEPTH words and is
// walked by one address counter, one entry per cycle. Append and any rejected request
// go from acceptance straight to the finish state. Insert at position p moves length-p+1
// entries, delete moves length-p entries and search reads up to length entries. The
// memory's read data is registered, and each moved word is written in the cycle after
// it is read. A new request is taken only when the previous result has entered the
// output register; a finished result may still wait in the output register while the
// next request is taken. No clearing pass is needed after reset: only entries below
// the length are read.
`default_nettype none

module array_list_engine_unit #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  ale_req_if.sink    req,
  ale_rsp_if.source  rsp
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FullLen = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FINISH
  } state_t;

  state_t             state;
  logic [CW-1:0]      len;
  ale_pkg::kind_t     kind_q;
  logic [CW-1:0]      pos_q;
  logic [WIDTH-1:0]   val_q;
  logic [CW-1:0]      ptr;
  logic [CW-1:0]      left;
  logic               rd_pend;
  logic [CW-1:0]      addr_q;
  ale_pkg::status_t   st_q;
  logic               fnd_q;
  logic [CW-1:0]      wh_q;

  logic               rsp_valid;
  logic [1:0]         rsp_status;
  logic               rsp_found;
  logic [CW-1:0]      rsp_where;
  logic [CW-1:0]      rsp_count;

  logic               we;
  logic [CW-1:0]      waddr;
  logic [WIDTH-1:0]   wdata;
  logic               re;
  logic [WIDTH-1:0]   rdata;
  logic               walk_done;
  logic               pos_bad;
  logic               full;

  assign req.ready  = (state == S_IDLE);
  assign rsp.valid  = rsp_valid;
  assign rsp.status = rsp_status;
  assign rsp.found  = rsp_found;
  assign rsp.where  = rsp_where;
  assign rsp.count  = rsp_count;

  assign full      = (len == FullLen);
  assign pos_bad   = (req.position == '0) || (req.position > len);
  assign walk_done = (left == '0) && !rd_pend;
  assign re        = (state == S_RUN) && (left != '0);

  // single write port: append in the accept cycle, moved words, then the inserted word
  always_comb begin
    we    = 1'b0;
    waddr = len;
    wdata = val_q;
    unique case (state)
      S_IDLE: begin
        if (req.valid && ale_pkg::kind_t'(req.kind) == ale_pkg::KIND_APPEND && !full) begin
          we    = 1'b1;
          waddr = len;
          wdata = req.value;
        end
      end
      S_RUN: begin
        if (rd_pend && kind_q != ale_pkg::KIND_SEARCH) begin
          we    = 1'b1;
          wdata = rdata;
          waddr = (kind_q == ale_pkg::KIND_INSERT) ? addr_q + 1'b1 : addr_q - 1'b1;
        end else if (walk_done && kind_q == ale_pkg::KIND_INSERT) begin
          we    = 1'b1;
          waddr = pos_q - 1'b1;
          wdata = val_q;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  ale_mem #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr[AW-1:0]),
    .wdata(wdata),
    .re   (re),
    .raddr(ptr[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // the finish state reloads the output register itself
      if (rsp_valid && rsp.ready && state != S_FINISH) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind_q  <= ale_pkg::kind_t'(req.kind);
            pos_q   <= req.position;
            val_q   <= req.value;
            fnd_q   <= 1'b0;
            wh_q    <= '0;
            st_q    <= ale_pkg::ST_DONE;
            rd_pend <= 1'b0;
            unique case (ale_pkg::kind_t'(req.kind))
              ale_pkg::KIND_APPEND: begin
                if (full) begin
                  st_q <= ale_pkg::ST_FULL;
                end else begin
                  len <= len + 1'b1;
                end
                state <= S_FINISH;
              end
              ale_pkg::KIND_INSERT: begin
                if (full) begin
                  st_q  <= ale_pkg::ST_FULL;
                  state <= S_FINISH;
                end else if (pos_bad) begin
                  st_q  <= ale_pkg::ST_RANGE;
                  state <= S_FINISH;
                end else begin
                  // walk from the tail down to the insert point
                  ptr   <= len - 1'b1;
                  left  <= len - req.position + 1'b1;
                  state <= S_RUN;
                end
              end
              ale_pkg::KIND_DELETE: begin
                if (pos_bad) begin
                  st_q  <= ale_pkg::ST_RANGE;
                  state <= S_FINISH;
                end else begin
                  ptr   <= req.position;
                  left  <= len - req.position;
                  state <= S_RUN;
                end
              end
              ale_pkg::KIND_SEARCH: begin
                ptr   <= '0;
                left  <= len;
                state <= S_RUN;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_RUN: begin
          rd_pend <= (left != '0);
          addr_q  <= ptr;
          if (left != '0) begin
            left <= left - 1'b1;
            ptr  <= (kind_q == ale_pkg::KIND_INSERT) ? ptr - 1'b1 : ptr + 1'b1;
          end
          if (kind_q == ale_pkg::KIND_SEARCH && rd_pend && rdata == val_q) begin
            // first match wins; any read still in flight is dropped
            fnd_q   <= 1'b1;
            wh_q    <= addr_q + 1'b1;
            rd_pend <= 1'b0;
            state   <= S_FINISH;
          end else if (walk_done) begin
            if (kind_q == ale_pkg::KIND_INSERT) begin
              len <= len + 1'b1;
            end else if (kind_q == ale_pkg::KIND_DELETE) begin
              len <= len - 1'b1;
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_status <= st_q;
            rsp_found  <= fnd_q;
            rsp_where  <= wh_q;
            rsp_count  <= len;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

`default_nettype wire

// ===== sv/ale_check.sv =====
// ale_check: port-level assertions for array_list_engine_unit, bound to the top level
// depends on ale_pkg and array_list_engine_unit
`default_nettype none

module ale_check #(
  parameter int DEPTH = 64,
  parameter int CW    = 7
) (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input logic [1:0]    rsp_status,
  input logic          rsp_found,
  input logic [CW-1:0] rsp_where,
  input logic [CW-1:0] rsp_count
);
  // a result waiting for the sink keeps its count and position
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count) && $stable(rsp_where))
    else $error("result changed while stalled");

  a_found_where: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_found == (rsp_where != '0)))
    else $error("found flag and position disagree");

  a_found_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found |->
      rsp_status == ale_pkg::ST_DONE && rsp_where <= rsp_count)
    else $error("match reported with bad status or beyond list length");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_count <= CW'(DEPTH))
    else $error("list length beyond depth");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ale_pkg::ST_FULL |-> rsp_count == CW'(DEPTH))
    else $error("full reported on a list that is not full");
endmodule

bind array_list_engine_unit ale_check #(
  .DEPTH(DEPTH),
  .CW   ($clog2(DEPTH + 1))
) u_ale_check (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_status(rsp.status),
  .rsp_found (rsp.found),
  .rsp_where (rsp.where),
  .rsp_count (rsp.count)
);

`default_nettype wire
